// ----- rtl/rplp_pkg.sv -----
// ----------------------------------------------------------------------------
// rplp_pkg - shared types and constants for the prefixed literal parser
// Payload structs, radix/status/phase codes and the character decode.
// ----------------------------------------------------------------------------
package rplp_pkg;

    // ASCII codes used by the prefix and digit decode
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_ONE     = 8'd49;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_UC_A    = 8'd65;
    localparam logic [7:0] CH_UC_B    = 8'd66;
    localparam logic [7:0] CH_UC_F    = 8'd70;
    localparam logic [7:0] CH_UC_X    = 8'd88;
    localparam logic [7:0] CH_LC_A    = 8'd97;
    localparam logic [7:0] CH_LC_B    = 8'd98;
    localparam logic [7:0] CH_LC_F    = 8'd102;
    localparam logic [7:0] CH_LC_X    = 8'd120;
    localparam logic [7:0] UC_OFFSET  = 8'd55;
    localparam logic [7:0] LC_OFFSET  = 8'd87;

    localparam logic [7:0] MAX_VALUE_RESET = 8'd255;

    // digit value 0..15, NO_DIGIT for anything else
    localparam logic [4:0] NO_DIGIT = 5'd16;

    typedef enum logic [1:0] {
        RX_BIN = 2'd0,
        RX_OCT = 2'd1,
        RX_DEC = 2'd2,
        RX_HEX = 2'd3
    } radix_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BAD_BIN = 3'd1,
        ST_BAD_OCT = 3'd2,
        ST_BAD_DEC = 3'd3,
        ST_BAD_HEX = 3'd4,
        ST_FORMAT  = 3'd5,
        ST_RANGE   = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_PREFIX = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic [1:0] radix_code;
        logic [2:0] status;
    } out_item_t;

    function automatic logic [4:0] digit_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c inside {[CH_ZERO:CH_NINE]})
            d = c - CH_ZERO;
        else if (c inside {[CH_UC_A:CH_UC_F]})
            d = c - UC_OFFSET;
        else if (c inside {[CH_LC_A:CH_LC_F]})
            d = c - LC_OFFSET;
        else
            d = {3'd0, NO_DIGIT};
        return d[4:0];
    endfunction

    function automatic logic [4:0] radix_base(input radix_t r);
        logic [4:0] b;
        case (r)
            RX_BIN:  b = 5'd2;
            RX_OCT:  b = 5'd8;
            RX_DEC:  b = 5'd10;
            RX_HEX:  b = 5'd16;
            default: b = 5'd16;
        endcase
        return b;
    endfunction

    function automatic status_t bad_digit_status(input radix_t r);
        status_t s;
        case (r)
            RX_BIN:  s = ST_BAD_BIN;
            RX_OCT:  s = ST_BAD_OCT;
            RX_DEC:  s = ST_BAD_DEC;
            RX_HEX:  s = ST_BAD_HEX;
            default: s = ST_BAD_HEX;
        endcase
        return s;
    endfunction

endpackage

// ----- rtl/radix_prefixed_literal_parser.sv -----
// ----------------------------------------------------------------------------
// radix_prefixed_literal_parser - C-style prefixed integer literal parser
// Takes one character per request, answers once per token with value,
// radix and status.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle unless the input is stalled. The
// token state (phase, radix, accumulator, overflow and first fault) sits in
// registers; each accepted character goes through one shift-and-add step
// and a digit check in the same cycle, so a new character can follow every
// cycle. The character that carries last produces the result, which appears
// in the output register on the next cycle. The input is stalled only while
// that register holds a stalled result. The user must write max_value via
// cfg_we/cfg_data only while idle, which is not enforced; resets to 255.
module radix_prefixed_literal_parser #(
    parameter int VALUE_WIDTH = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rplp_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rplp_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_data
);
    import rplp_pkg::*;

    localparam int XW = VALUE_WIDTH + 5;   // room for acc*16 + 15

    // token state
    phase_t                   phase_reg,  phase_next;
    radix_t                   radix_reg,  radix_next;
    logic [VALUE_WIDTH-1:0]   acc_reg,    acc_next;
    logic                     ovf_reg,    ovf_next;
    status_t                  err_reg,    err_next;

    logic [7:0]               max_value_reg;

    // result register
    logic                     out_valid_reg;
    out_item_t                out_data_reg, out_data_next;

    logic                     accept;
    logic [7:0]               c;
    logic [4:0]               dig;
    logic                     do_take;
    radix_t                   take_radix;
    logic [XW-1:0]            acc_ext;
    logic [XW-1:0]            acc_mul;
    logic [XW-1:0]            acc_sum;

    assign in_stall  = out_valid_reg & out_stall;
    assign accept    = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign c   = in_data.char_in;
    assign dig = digit_of(c);

    // a first character can only be taken as a decimal digit
    assign take_radix = (phase_reg == PH_FIRST) ? RX_DEC : radix_reg;

    // multiply-accumulate: binary, octal and hex are shifts, decimal is 8x + 2x
    assign acc_ext = XW'(acc_reg);
    always_comb
    begin
        case (take_radix)
            RX_BIN:  acc_mul = acc_ext << 1;
            RX_OCT:  acc_mul = acc_ext << 3;
            RX_DEC:  acc_mul = (acc_ext << 3) + (acc_ext << 1);
            RX_HEX:  acc_mul = acc_ext << 4;
            default: acc_mul = acc_ext << 4;
        endcase
    end
    assign acc_sum = acc_mul + XW'(dig);

    // next token state
    always_comb
    begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        do_take    = 1'b0;

        case (phase_reg)
            PH_FIRST:
            begin
                phase_next = PH_DIGITS;
                if (c == CH_ZERO)
                begin
                    radix_next = RX_OCT;
                    phase_next = PH_PREFIX;
                end
                else if (c inside {[CH_ONE:CH_NINE]})
                begin
                    radix_next = RX_DEC;
                    do_take    = 1'b1;
                end
                else
                begin
                    // not a literal at all
                    radix_next = RX_BIN;
                    err_next   = ST_FORMAT;
                end
            end
            PH_PREFIX:
            begin
                phase_next = PH_DIGITS;
                if (c == CH_LC_B || c == CH_UC_B)
                    radix_next = RX_BIN;
                else if (c == CH_LC_X || c == CH_UC_X)
                    radix_next = RX_HEX;
                else
                    do_take = 1'b1;
            end
            default:
            begin
                // digits phase; the unused code behaves the same
                do_take = 1'b1;
            end
        endcase

        // first fault is sticky; a digit fault outranks overflow
        if (do_take && err_reg == ST_OK)
        begin
            if (dig >= radix_base(take_radix))
                err_next = bad_digit_status(take_radix);
            else if (!ovf_reg)
            begin
                if (|acc_sum[XW-1:VALUE_WIDTH])
                    ovf_next = 1'b1;
                else
                    acc_next = acc_sum[VALUE_WIDTH-1:0];
            end
        end
    end

    // result for a token ending on this character
    always_comb
    begin
        out_data_next.value      = 8'd0;
        out_data_next.radix_code = radix_next;
        out_data_next.status     = ST_OK;
        if (err_next != ST_OK)
            out_data_next.status = err_next;
        else if (ovf_next || acc_next > VALUE_WIDTH'(max_value_reg))
            out_data_next.status = ST_RANGE;
        else
            out_data_next.value = acc_next[7:0];
        if (err_next == ST_FORMAT)
            out_data_next.radix_code = RX_BIN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIRST;
            radix_reg     <= RX_BIN;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            err_reg       <= ST_OK;
            max_value_reg <= MAX_VALUE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                max_value_reg <= cfg_data;

            if (accept && in_data.last)
            begin
                // token done: back to the reset state
                phase_reg <= PH_FIRST;
                radix_reg <= RX_BIN;
                acc_reg   <= '0;
                ovf_reg   <= 1'b0;
                err_reg   <= ST_OK;
            end
            else if (accept)
            begin
                phase_reg <= phase_next;
                radix_reg <= radix_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
                err_reg   <= err_next;
            end

            if (accept && in_data.last)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_data.last)
            out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid_reg)
        else $error("input stalled with an empty result register");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=> out_valid_reg)
        else $error("token end did not load a result");

    a_token_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last) |=>
            (phase_reg == PH_FIRST && err_reg == ST_OK && !ovf_reg && acc_reg == '0))
        else $error("token state not cleared after token end");

    a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status != ST_OK) |-> out_data_reg.value == 8'd0)
        else $error("non-zero value on a failed token");

    a_format_radix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.status == ST_FORMAT)
            |-> out_data_reg.radix_code == RX_BIN)
        else $error("radix code not cleared on invalid format");
`endif

endmodule
